/* src/sm4c_pkg.sv */
// ----------------------------------------------------------------------------
// sm4c_pkg
// Shared types, constants and round functions of the SM4 CBC cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4c_pkg;

  localparam int ROUNDS  = 32;
  localparam int RK_AW   = 5;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 64;

  typedef logic [127:0] block_t;

  // register indexes of the configuration port
  typedef enum logic [CFG_AW-1:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_DECRYPT  = 3'd4
  } cfg_reg_t;

  localparam logic [127:0] FK = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // key schedule constant: byte j of word i is (4i + j) * 7 mod 256
  function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
    logic [31:0] w;
    logic [7:0]  idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'(j)};
      w   = {w[23:0], 8'(idx * 8'd7)};
    end
    return w;
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] b, input int n);
    return (b << n) | (b >> (32 - n));
  endfunction

  // linear layer of the data rounds
  function automatic logic [31:0] l_data(input logic [31:0] b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // linear layer of the key schedule
  function automatic logic [31:0] l_key(input logic [31:0] b);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

endpackage

`default_nettype wire

/* src/sm4c_if.sv */
// ----------------------------------------------------------------------------
// sm4c_if
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm4c_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        first_block;
  logic        message_end;

  modport source (output valid, data_high, data_low, first_block, message_end,
                  input ready);
  modport sink (input valid, data_high, data_low, first_block, message_end,
                output ready);
endinterface

interface sm4c_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        end_of_message;

  modport source (output valid, result_high, result_low, end_of_message,
                  input ready);
  modport sink (input valid, result_high, result_low, end_of_message,
                output ready);
endinterface

`default_nettype wire

/* src/sm4c_ram.sv */
// ----------------------------------------------------------------------------
// sm4c_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4c_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/sm4_cbc_cipher.sv */
// ----------------------------------------------------------------------------
// sm4_cbc_cipher
// SM4-128 in CBC mode: key schedule into a round-key RAM, one round a cycle.
// ----------------------------------------------------------------------------
// flow: an accepted block runs its rounds in S_ROUND; after a key write the
//   next block first runs the key schedule in S_KEY (one round key a cycle)
// blocks: a new block is taken only in S_IDLE, after the last one has left
//   S_ROUND or S_WAIT for the output register; one shared round unit serves both
// reset: synchronous; clears state, key, IV, mode, chain, key-valid, out valid
`default_nettype none

module sm4_cbc_cipher
  import sm4c_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  sm4c_in_if.sink                in,
  sm4c_out_if.source             out
);

  typedef enum logic [1:0] {S_IDLE, S_KEY, S_ROUND, S_WAIT} state_t;

  state_t           state;
  logic [RK_AW-1:0] cnt;
  logic [127:0]     key;
  logic [127:0]     iv;
  logic             decrypt_mode;
  logic             keys_valid;
  block_t           chain;
  block_t           blk;
  logic             eom;
  logic [31:0]      x [4];
  logic             out_valid;
  block_t           out_blk;
  logic             out_eom;
  logic             byp_valid;
  logic [31:0]      byp_data;

  logic             ram_we;
  logic [RK_AW-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [RK_AW-1:0] ram_raddr;
  logic [31:0]      ram_rdata;
  logic [RK_AW-1:0] rd_round;

  logic [31:0]      rk_in;
  logic [31:0]      t;
  logic [31:0]      nx;
  block_t           start_blk;
  block_t           start_chain;
  block_t           init_blk;
  block_t           fin;
  block_t           res;
  block_t           chain_next;
  logic             out_free;
  logic             out_load;

  sm4c_ram #(.WIDTH(32), .DEPTH(ROUNDS)) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared round unit: key schedule or data round
  always_comb begin
    if (state == S_KEY) begin
      rk_in = ck_word(cnt);
    end else if (byp_valid) begin
      rk_in = byp_data;
    end else begin
      rk_in = ram_rdata;
    end
    t  = tau(x[1] ^ x[2] ^ x[3] ^ rk_in);
    nx = x[0] ^ ((state == S_KEY) ? l_key(t) : l_data(t));
  end

  assign ram_we    = (state == S_KEY);
  assign ram_waddr = cnt;
  assign ram_wdata = nx;
  // address one round ahead; decryption walks the keys backward
  assign rd_round  = (state == S_ROUND) ? cnt + 1'b1 : '0;
  assign ram_raddr = decrypt_mode ? ~rd_round : rd_round;

  always_comb begin
    if (state == S_IDLE) begin
      start_blk   = {in.data_high, in.data_low};
      start_chain = in.first_block ? iv : chain;
    end else begin
      start_blk   = blk;
      start_chain = chain;
    end
    init_blk   = decrypt_mode ? start_blk : (start_blk ^ start_chain);
    fin        = (state == S_ROUND) ? {nx, x[3], x[2], x[1]} : {x[3], x[2], x[1], x[0]};
    res        = decrypt_mode ? (fin ^ chain) : fin;
    chain_next = decrypt_mode ? blk : res;
  end

  assign out_free           = !out_valid || out.ready;
  // finished block moves into the output register this cycle
  assign out_load           = out_free && ((state == S_WAIT) ||
                              (state == S_ROUND && cnt == RK_AW'(ROUNDS - 1)));
  assign in.ready           = (state == S_IDLE);
  assign out.valid          = out_valid;
  assign out.result_high    = out_blk[127:64];
  assign out.result_low     = out_blk[63:0];
  assign out.end_of_message = out_eom;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      key          <= '0;
      iv           <= '0;
      decrypt_mode <= 1'b0;
      keys_valid   <= 1'b0;
      chain        <= '0;
      out_valid    <= 1'b0;
      byp_valid    <= 1'b0;
    end else begin
      // read of an entry written at the same edge returns the new word
      byp_valid <= ram_we && (ram_waddr == ram_raddr);
      byp_data  <= ram_wdata;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in.valid) begin
            blk <= {in.data_high, in.data_low};
            eom <= in.message_end;
            cnt <= '0;
            if (in.first_block) begin
              chain <= iv;
            end
            if (keys_valid) begin
              {x[0], x[1], x[2], x[3]} <= init_blk;
              state <= S_ROUND;
            end else begin
              {x[0], x[1], x[2], x[3]} <= key ^ FK;
              state <= S_KEY;
            end
          end
        end
        S_KEY: begin
          cnt <= cnt + 1'b1;
          if (cnt == RK_AW'(ROUNDS - 1)) begin
            keys_valid <= 1'b1;
            {x[0], x[1], x[2], x[3]} <= init_blk;
            state <= S_ROUND;
          end else begin
            {x[0], x[1], x[2], x[3]} <= {x[1], x[2], x[3], nx};
          end
        end
        S_ROUND: begin
          cnt <= cnt + 1'b1;
          {x[0], x[1], x[2], x[3]} <= {x[1], x[2], x[3], nx};
          if (cnt == RK_AW'(ROUNDS - 1)) begin
            if (out_free) begin
              out_blk   <= res;
              out_eom   <= eom;
              chain     <= chain_next;
              state     <= S_IDLE;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (out_free) begin
            out_blk   <= res;
            out_eom   <= eom;
            chain     <= chain_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_KEY_HIGH: begin
            key[127:64] <= cfg_data;
            keys_valid  <= 1'b0;
          end
          REG_KEY_LOW: begin
            key[63:0]  <= cfg_data;
            keys_valid <= 1'b0;
          end
          REG_IV_HIGH: iv[127:64]   <= cfg_data;
          REG_IV_LOW:  iv[63:0]     <= cfg_data;
          REG_DECRYPT: decrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_round_keys_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> keys_valid)
    else $error("data round running without expanded keys");

  a_keys_done: assert property (@(posedge clk) disable iff (rst)
    $rose(keys_valid) |-> $past(state == S_KEY && cnt == RK_AW'(ROUNDS - 1)))
    else $error("keys marked valid before the schedule finished");

  a_start_round: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready && keys_valid && !cfg_wr_en) |=> (state == S_ROUND && cnt == '0))
    else $error("block with expanded keys did not start at round zero");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ROUND || state == S_WAIT))
    else $error("result appeared without a finished block");
`endif

endmodule

`default_nettype wire
